/* design/ole_pkg.sv */
// package for the ordered list engine: sizes, opcodes, status codes, states
// no dependencies
package ole_pkg;
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_INSERT_BACK = 3'd0,
        OP_INSERT_AT   = 3'd1,
        OP_REMOVE_AT   = 3'd2,
        OP_ELEMENT_AT  = 3'd3,
        OP_CONTAINS    = 3'd4,
        OP_DEDUP       = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_REM_RD,
        S_REM_WR,
        S_READ,
        S_SRCH,
        S_DD_RDI,
        S_DD_RDJ,
        S_DD_CMP,
        S_DONE
    } state_t;
endpackage

/* design/ordered_list_engine.sv */
// top level of the ordered list engine: request/response streams around a
// list memory with one read and one write port, walked by a sequencer; depends on ole_pkg
//
// Requests arrive one beat at a time and each gives one response beat. The
// list lives in a memory of CAPACITY words with registered read data, and a
// sequencer steps through it one entry per access. Insert and remove shift
// the tail one entry at a time, reading each moved entry and then writing it
// back one place along; contains scans the list at one entry per cycle;
// duplicate removal compares each entry against the kept prefix at about one
// compare per cycle. A new request is taken once the previous response has
// left the output register.
module ordered_list_engine
    import ole_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // opcode[2:0], position[9:3], item_value[41:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // data_out[31:0], found[32], status[34:33], entry_count[41:35]
);
    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic                  we;
    logic [ADDR_W-1:0]     waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata, rdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [2:0]            op_reg, op_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [CNT_W-1:0]      i_reg, i_next, j_reg, j_next, w_reg, w_next;
    logic [DATA_WIDTH-1:0] cur_reg, cur_next;
    logic [DATA_WIDTH-1:0] dout_reg, dout_next;
    logic                  found_reg, found_next;
    status_t               st_reg, st_next;
    logic                  mv_reg, mv_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        w_reg     <= w_next;
        cur_reg   <= cur_next;
        dout_reg  <= dout_next;
        found_reg <= found_next;
        st_reg    <= st_next;
    end

    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {6'd0, count_reg, st_reg, found_reg, dout_reg};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        op_next    = op_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        w_next     = w_reg;
        cur_next   = cur_reg;
        dout_next  = dout_reg;
        found_next = found_reg;
        st_next    = st_reg;
        mv_next    = mv_reg && !m_tready;
        we         = 1'b0;
        waddr      = '0;
        wdata      = val_reg;
        raddr      = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    op_next    = s_tdata[2:0];
                    pos_next   = s_tdata[9:3];
                    val_next   = s_tdata[41:10];
                    dout_next  = '0;
                    found_next = 1'b0;
                    st_next    = ST_OK;
                    i_next     = '0;
                    state_next = S_DONE;
                    case (s_tdata[2:0])
                        OP_INSERT_BACK:
                            if (count_reg >= CNT_W'(CAPACITY))
                                st_next = ST_FULL;
                            else
                            begin
                                pos_next   = count_reg;
                                i_next     = count_reg;
                                state_next = S_INS_RD;
                            end
                        OP_INSERT_AT:
                            if (s_tdata[9:3] > count_reg)
                                st_next = ST_RANGE;
                            else if (count_reg >= CNT_W'(CAPACITY))
                                st_next = ST_FULL;
                            else
                            begin
                                i_next     = count_reg;
                                state_next = S_INS_RD;
                            end
                        OP_REMOVE_AT, OP_ELEMENT_AT:
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else if (s_tdata[9:3] >= count_reg)
                                st_next = ST_RANGE;
                            else
                            begin
                                i_next     = s_tdata[9:3];
                                state_next = (s_tdata[2:0] == OP_REMOVE_AT) ? S_REM_RD
                                                                             : S_READ;
                            end
                        OP_CONTAINS:
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else
                                state_next = S_SRCH;
                        OP_DEDUP:
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else
                            begin
                                w_next     = '0;
                                state_next = S_DD_RDI;
                            end
                        default: ;
                    endcase
                end
            end
            // shift up: read i-1, then write it to i
            S_INS_RD:
            begin
                if (i_reg == pos_reg)
                begin
                    we         = 1'b1;
                    waddr      = pos_reg[ADDR_W-1:0];
                    wdata      = val_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    raddr      = ADDR_W'(i_reg - 1'b1);
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                we         = 1'b1;
                waddr      = i_reg[ADDR_W-1:0];
                wdata      = rdata;
                i_next     = i_reg - 1'b1;
                state_next = S_INS_RD;
            end
            // first read at pos gives removed word, then shift down
            S_REM_RD:
            begin
                raddr      = ADDR_W'(i_reg + 1'b1);
                if (i_reg == pos_reg && !found_reg)
                    raddr = i_reg[ADDR_W-1:0];
                state_next = S_REM_WR;
            end
            S_REM_WR:
            begin
                if (i_reg == pos_reg && !found_reg)
                begin
                    dout_next  = rdata;
                    found_next = 1'b1;
                    state_next = S_REM_RD;
                    if (i_reg + 1'b1 >= count_reg)
                    begin
                        found_next = 1'b0;
                        count_next = count_reg - 1'b1;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    we     = 1'b1;
                    waddr  = i_reg[ADDR_W-1:0];
                    wdata  = rdata;
                    i_next = i_reg + 1'b1;
                    state_next = S_REM_RD;
                    if (i_reg + 2'd2 >= count_reg)
                    begin
                        found_next = 1'b0;
                        count_next = count_reg - 1'b1;
                        state_next = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                raddr      = i_reg[ADDR_W-1:0];
                i_next     = '0;
                state_next = S_SRCH;
                if (op_reg == OP_ELEMENT_AT)
                    state_next = S_DD_CMP;
            end
            // linear search: issue read i, compare previous read
            S_SRCH:
            begin
                raddr = i_reg[ADDR_W-1:0];
                if (i_reg != '0 && rdata == val_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (i_reg == count_reg)
                    state_next = S_DONE;
                else
                    i_next = i_reg + 1'b1;
            end
            // dedup: cur = entries[i]; compare against entries[0..w-1]
            S_DD_RDI:
            begin
                raddr      = i_reg[ADDR_W-1:0];
                j_next     = '0;
                state_next = S_DD_RDJ;
            end
            S_DD_RDJ:
            begin
                cur_next = rdata;
                if (w_reg == '0)
                begin
                    we         = 1'b1;
                    waddr      = '0;
                    wdata      = rdata;
                    w_next     = CNT_W'(1);
                    i_next     = i_reg + 1'b1;
                    state_next = (i_reg + 1'b1 >= count_reg) ? S_DONE : S_DD_RDI;
                    if (i_reg + 1'b1 >= count_reg)
                        count_next = CNT_W'(1);
                end
                else
                begin
                    raddr      = '0;
                    j_next     = CNT_W'(1);
                    state_next = S_DD_CMP;
                end
            end
            S_DD_CMP:
            begin
                if (op_reg == OP_ELEMENT_AT)
                begin
                    dout_next  = rdata;
                    state_next = S_DONE;
                end
                else if (rdata == cur_reg || j_reg == w_reg)
                begin
                    if (rdata != cur_reg)
                    begin
                        we     = 1'b1;
                        waddr  = w_reg[ADDR_W-1:0];
                        wdata  = cur_reg;
                        w_next = w_reg + 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                    if (i_reg + 1'b1 >= count_reg)
                    begin
                        count_next = (rdata != cur_reg) ? w_reg + 1'b1 : w_reg;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_DD_RDI;
                end
                else
                begin
                    raddr  = j_reg[ADDR_W-1:0];
                    j_next = j_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!mv_reg)
                begin
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("request taken while response pending");
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[34:33] == ST_FULL) |-> m_tdata[41:35] == 7'(CAPACITY))
        else $error("full status without full list");
endmodule

/* dv/ordered_list_engine_tb.sv */
// self-checking testbench for ordered_list_engine: directed and random requests
// through the request stream, with responses checked against an in-bench list model
// depends on ole_pkg and ordered_list_engine
module ordered_list_engine_tb;
    import ole_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;    // opcode[2:0], position[9:3], item_value[41:10]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // data_out[31:0], found[32], status[34:33], entry_count[41:35]

    logic [47:0] request_q[$];
    logic [47:0] response_q[$];

    logic [31:0] list_words[CAPACITY];
    int          list_len = 0;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_request = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    bit  failed = 1'b0;

    ordered_list_engine dut (.*);

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic logic [47:0] pack_request(opcode_t op, int pos, logic [31:0] val);
        return {6'd0, val, pos[6:0], op};
    endfunction

    // apply one request to the list model and return the response it should give
    function automatic logic [47:0] apply_request(logic [47:0] req);
        logic [2:0]  op;
        int          pos;
        logic [31:0] val;
        logic [31:0] data;
        logic        hit;
        status_t     st;
        int          w;
        bit          dup;
        op   = req[2:0];
        pos  = req[9:3];
        val  = req[41:10];
        data = '0;
        hit  = 1'b0;
        st   = ST_OK;
        case (op)
            OP_INSERT_BACK:
            begin
                if (list_len >= CAPACITY)
                    st = ST_FULL;
                else
                begin
                    list_words[list_len] = val;
                    list_len++;
                end
            end
            OP_INSERT_AT:
            begin
                if (pos > list_len)
                    st = ST_RANGE;
                else if (list_len >= CAPACITY)
                    st = ST_FULL;
                else
                begin
                    for (int i = list_len; i > pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = val;
                    list_len++;
                end
            end
            OP_REMOVE_AT:
            begin
                if (list_len == 0)
                    st = ST_EMPTY;
                else if (pos >= list_len)
                    st = ST_RANGE;
                else
                begin
                    data = list_words[pos];
                    for (int i = pos; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            OP_ELEMENT_AT:
            begin
                if (list_len == 0)
                    st = ST_EMPTY;
                else if (pos >= list_len)
                    st = ST_RANGE;
                else
                    data = list_words[pos];
            end
            OP_CONTAINS:
            begin
                if (list_len == 0)
                    st = ST_EMPTY;
                else
                    for (int i = 0; i < list_len; i++)
                        if (list_words[i] == val)
                            hit = 1'b1;
            end
            OP_DEDUP:
            begin
                if (list_len == 0)
                    st = ST_EMPTY;
                else
                begin
                    w = 0;
                    for (int i = 0; i < list_len; i++)
                    begin
                        dup = 1'b0;
                        for (int j = 0; j < w; j++)
                            if (list_words[j] == list_words[i])
                                dup = 1'b1;
                        if (!dup)
                        begin
                            list_words[w] = list_words[i];
                            w++;
                        end
                    end
                    list_len = w;
                end
            end
            default:
            begin
            end
        endcase
        return {6'd0, 7'(list_len), st, hit, data};
    endfunction

    // random request; insert_pct sets how hard the list is pushed toward full
    function automatic logic [47:0] random_request(int insert_pct);
        int          r;
        int          pos;
        logic [31:0] val;
        opcode_t     op;
        r = $urandom_range(0, 99);
        if (r < insert_pct / 2)
            op = OP_INSERT_BACK;
        else if (r < insert_pct)
            op = OP_INSERT_AT;
        else if (r < insert_pct + (100 - insert_pct) * 35 / 100)
            op = OP_REMOVE_AT;
        else if (r < insert_pct + (100 - insert_pct) * 60 / 100)
            op = OP_ELEMENT_AT;
        else if (r < insert_pct + (100 - insert_pct) * 85 / 100)
            op = OP_CONTAINS;
        else if (r < 98)
            op = OP_DEDUP;
        else
            op = opcode_t'($urandom_range(6, 7));
        case ($urandom_range(0, 3))
            0: pos = $urandom_range(0, 4);
            1: pos = $urandom_range(0, 64);
            2: pos = $urandom_range(0, 127);
            default: pos = $urandom_range(40, 66);
        endcase
        // a small pool of values keeps duplicates and search hits common
        if ($urandom_range(0, 1))
            val = 32'hA5000000 + $urandom_range(0, 7);
        else
            val = $urandom;
        return pack_request(op, pos, val);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                response_q.push_back(apply_request(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= request_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_request && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end

    always @(posedge clk)
    begin
        logic [47:0] exp_beat;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (response_q.size() == 0)
            begin
                $display("%0t: unexpected response beat %h", $time, m_tdata);
                failed = 1'b1;
            end
            else
            begin
                exp_beat = response_q.pop_front();
                if (m_tdata[31:0] !== exp_beat[31:0])
                begin
                    $display("%0t: data_out expected %h actual %h",
                             $time, exp_beat[31:0], m_tdata[31:0]);
                    failed = 1'b1;
                end
                if (m_tdata[32] !== exp_beat[32])
                begin
                    $display("%0t: found expected %b actual %b",
                             $time, exp_beat[32], m_tdata[32]);
                    failed = 1'b1;
                end
                if (m_tdata[34:33] !== exp_beat[34:33])
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_beat[34:33], m_tdata[34:33]);
                    failed = 1'b1;
                end
                if (m_tdata[41:35] !== exp_beat[41:35])
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, exp_beat[41:35], m_tdata[41:35]);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        #25000000;
        $display("ordered_list_engine test failed");
        $finish;
    end

    initial
    begin
        int idle_pct[4];
        int stall_pct[4];
        int ins_pct[4];
        idle_pct  = '{0, 76, 0, 14};
        stall_pct = '{0, 0, 76, 14};
        ins_pct   = '{70, 45, 60, 35};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty list, unused opcodes, bad insert position, end cases
        request_q.push_back(pack_request(OP_REMOVE_AT, 0, 32'd0));
        request_q.push_back(pack_request(OP_ELEMENT_AT, 0, 32'd0));
        request_q.push_back(pack_request(OP_CONTAINS, 0, 32'd0));
        request_q.push_back(pack_request(OP_DEDUP, 0, 32'd0));
        request_q.push_back(pack_request(opcode_t'(3'd6), 127, 32'hFFFFFFFF));
        request_q.push_back(pack_request(opcode_t'(3'd7), 0, 32'd0));
        request_q.push_back(pack_request(OP_INSERT_AT, 1, 32'd1));
        request_q.push_back(pack_request(OP_INSERT_AT, 0, 32'hFFFFFFFF));
        request_q.push_back(pack_request(OP_INSERT_BACK, 127, 32'd0));
        request_q.push_back(pack_request(OP_INSERT_BACK, 0, 32'd5));
        request_q.push_back(pack_request(OP_INSERT_BACK, 0, 32'd0));
        request_q.push_back(pack_request(OP_CONTAINS, 0, 32'd5));
        request_q.push_back(pack_request(OP_CONTAINS, 0, 32'd7));
        request_q.push_back(pack_request(OP_ELEMENT_AT, 1, 32'd0));
        request_q.push_back(pack_request(OP_ELEMENT_AT, 4, 32'd0));
        request_q.push_back(pack_request(OP_INSERT_AT, 4, 32'hFFFFFFFF));
        request_q.push_back(pack_request(OP_INSERT_AT, 2, 32'd5));
        request_q.push_back(pack_request(OP_REMOVE_AT, 127, 32'd0));
        request_q.push_back(pack_request(OP_REMOVE_AT, 64, 32'd0));
        request_q.push_back(pack_request(OP_DEDUP, 0, 32'd0));
        request_q.push_back(pack_request(OP_ELEMENT_AT, 0, 32'd0));
        request_q.push_back(pack_request(OP_REMOVE_AT, 0, 32'd0));

        for (int ph = 0; ph < 4; ph++)
        begin
            wait (request_q.size() == 0 && response_q.size() == 0);
            @(posedge clk);
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            if (ph == 0)
                hold_request = 1'b1;
            for (int n = 0; n < 250; n++)
                request_q.push_back(random_request(ins_pct[ph]));
        end

        wait (request_q.size() == 0 && !s_tvalid && response_q.size() == 0);
        repeat (5000)
        begin
            @(posedge clk);
            if (m_tvalid)
                break;
        end
        repeat (20) @(posedge clk);
        if (!failed && response_q.size() == 0)
            $display("ordered_list_engine test passed");
        else
            $display("ordered_list_engine test failed");
        $finish;
    end
endmodule
